// ===== src/tmw_pkg.sv =====
package tmw_pkg;

   // Default screen geometry
   localparam int SCREEN_WIDTH_DEF  = 80;
   localparam int SCREEN_HEIGHT_DEF = 25;

   // Cell store address bus, wide enough for the largest screen (128 x 32)
   localparam int MEM_ADDR_W = 14;

   // Character codes
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_RETURN  = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // Blank color after reset
   localparam logic [7:0] BLANK_COLOR_RESET = 8'h0F;

   // Command codes
   typedef enum logic [2:0] {
      OP_PUT    = 3'd0,
      OP_BKSP   = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_SETCUR = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Access request from the controller to the cell store
   typedef struct packed {
      logic                  we;
      logic [MEM_ADDR_W-1:0] waddr;
      logic [15:0]           wdata;
      logic                  re;
      logic [MEM_ADDR_W-1:0] raddr;
   } ram_req_type;

endpackage

// ===== src/tmw_cell_ram.sv =====
module tmw_cell_ram #(
   parameter int SCREEN_WIDTH  = tmw_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tmw_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                  clock,
   input  tmw_pkg::ram_req_type  ram_req,
   output logic [15:0]           rd_data
);

   localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);

   logic [15:0] mem [CELLS];
   logic [15:0] rd_data_ff;

   // One write port
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr[ADDR_W-1:0]] <= ram_req.wdata;
      end
   end

   // One read port, registered; data holds until the next read
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tmw_ctrl.sv =====
module tmw_ctrl #(
   parameter int SCREEN_WIDTH  = tmw_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tmw_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command side
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_op,
   input  logic [7:0]            req_char_code,
   input  logic [7:0]            req_char_color,
   input  logic [4:0]            req_target_row,
   input  logic [6:0]            req_target_col,
   // result side
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_cell_value,
   output logic [4:0]            rsp_cursor_row_now,
   output logic [6:0]            rsp_cursor_col_now,
   // configuration
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   // cell store
   output tmw_pkg::ram_req_type  ram_req,
   input  logic [15:0]           rd_data
);

   localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
   localparam int COL_W  = $clog2(SCREEN_WIDTH);

   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_HEIGHT - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_WIDTH - 1);
   localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

   // Logical row -> store address; rows live in a ring starting at top
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] lrow,
                                                   input logic [ROW_W-1:0] top,
                                                   input logic [COL_W-1:0] col);
      logic [ROW_W:0] prow;
      prow = (ROW_W+1)'(lrow) + (ROW_W+1)'(top);
      if (prow >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
         prow = prow - (ROW_W+1)'(SCREEN_HEIGHT);
      end
      return ADDR_W'(ADDR_W'(prow) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(col);
   endfunction

   tmw_pkg::state_type state_ff, state_in;

   logic [ROW_W-1:0]  crow_ff, crow_in;
   logic [COL_W-1:0]  ccol_ff, ccol_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [7:0]        blank_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_cell_ff, rsp_cell_in;
   logic [4:0]        rsp_row_ff, rsp_row_in;
   logic [6:0]        rsp_col_ff, rsp_col_in;

   logic              out_free;
   logic              accept;
   logic              is_nl;
   logic              is_cr;
   logic              col_last;
   logic              row_last;
   logic              wrap;
   logic              scroll_needed;
   logic              sweep_end;
   logic [7:0]        trow_ext;
   logic [7:0]        tcol_ext;
   logic [ROW_W-1:0]  trow;
   logic [COL_W-1:0]  tcol;
   logic [ROW_W-1:0]  top_next;
   logic [ADDR_W-1:0] scroll_base;

   // Handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == tmw_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Command decode
   assign is_nl    = (req_char_code == tmw_pkg::CH_NEWLINE);
   assign is_cr    = (req_char_code == tmw_pkg::CH_RETURN);
   assign col_last = (ccol_ff == COL_LAST);
   assign row_last = (crow_ff == ROW_LAST);
   assign wrap     = is_nl || (!is_cr && col_last);
   assign scroll_needed = accept && (req_op == tmw_pkg::OP_PUT) && wrap && row_last;
   assign sweep_end = (sweep_ff == end_ff);

   // Target clamp to the screen
   assign trow_ext = 8'(req_target_row);
   assign tcol_ext = 8'(req_target_col);
   assign trow = (trow_ext > 8'(SCREEN_HEIGHT - 1)) ? ROW_LAST : trow_ext[ROW_W-1:0];
   assign tcol = (tcol_ext > 8'(SCREEN_WIDTH - 1))  ? COL_LAST : tcol_ext[COL_W-1:0];

   // Scroll: the old top row turns into the new bottom row
   assign top_next    = (top_ff == ROW_LAST) ? '0 : top_ff + 1'b1;
   assign scroll_base = ADDR_W'(ADDR_W'(top_ff) * ADDR_W'(SCREEN_WIDTH));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmw_pkg::ST_INIT: begin
            if (sweep_end) state_in = tmw_pkg::ST_IDLE;
         end
         tmw_pkg::ST_IDLE: begin
            if (accept) begin
               if (scroll_needed) begin
                  state_in = tmw_pkg::ST_SCROLL;
               end else if (req_op == tmw_pkg::OP_CLEAR) begin
                  state_in = tmw_pkg::ST_CLEAR;
               end else if (req_op == tmw_pkg::OP_READ) begin
                  state_in = tmw_pkg::ST_READ;
               end
            end
         end
         tmw_pkg::ST_SCROLL,
         tmw_pkg::ST_CLEAR: begin
            if (sweep_end) state_in = tmw_pkg::ST_DONE;
         end
         tmw_pkg::ST_READ,
         tmw_pkg::ST_DONE: begin
            if (out_free) state_in = tmw_pkg::ST_IDLE;
         end
         default: state_in = tmw_pkg::ST_IDLE;
      endcase
   end

   // Datapath, store accesses and result
   always_comb begin
      logic load_rsp;
      crow_in     = crow_ff;
      ccol_in     = ccol_ff;
      top_in      = top_ff;
      sweep_in    = sweep_ff;
      end_in      = end_ff;
      load_rsp    = 1'b0;
      rsp_cell_in = rsp_cell_ff;
      ram_req     = '0;

      unique case (state_ff)
         tmw_pkg::ST_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = tmw_pkg::MEM_ADDR_W'(sweep_ff);
            ram_req.wdata = '0;
            sweep_in      = sweep_ff + 1'b1;
         end
         tmw_pkg::ST_IDLE: begin
            if (accept) begin
               load_rsp    = 1'b1;
               rsp_cell_in = '0;
               case (req_op)
                  tmw_pkg::OP_PUT: begin
                     if (!is_nl && !is_cr) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = tmw_pkg::MEM_ADDR_W'(cell_addr(crow_ff, top_ff, ccol_ff));
                        ram_req.wdata = {req_char_color, req_char_code};
                        ccol_in       = ccol_ff + 1'b1;
                     end
                     if (is_cr) ccol_in = '0;
                     if (wrap) begin
                        ccol_in = '0;
                        if (row_last) begin
                           // scroll: result goes out after the row blank
                           load_rsp = 1'b0;
                           top_in   = top_next;
                           sweep_in = scroll_base;
                           end_in   = scroll_base + ADDR_W'(SCREEN_WIDTH - 1);
                        end else begin
                           crow_in = crow_ff + 1'b1;
                        end
                     end
                  end
                  tmw_pkg::OP_BKSP: begin
                     if (ccol_ff != '0) begin
                        ccol_in       = ccol_ff - 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.waddr = tmw_pkg::MEM_ADDR_W'(
                                           cell_addr(crow_ff, top_ff, ccol_ff - 1'b1));
                        ram_req.wdata = {blank_ff, tmw_pkg::CH_SPACE};
                     end
                  end
                  tmw_pkg::OP_CLEAR: begin
                     load_rsp = 1'b0;
                     crow_in  = '0;
                     ccol_in  = '0;
                     top_in   = '0;
                     sweep_in = '0;
                     end_in   = CELL_LAST;
                  end
                  tmw_pkg::OP_SETCUR: begin
                     crow_in = trow;
                     ccol_in = tcol;
                  end
                  tmw_pkg::OP_READ: begin
                     // no write is in flight here, so the read sees current data
                     load_rsp      = 1'b0;
                     ram_req.re    = 1'b1;
                     ram_req.raddr = tmw_pkg::MEM_ADDR_W'(cell_addr(trow, top_ff, tcol));
                  end
                  default: ;
               endcase
            end
         end
         tmw_pkg::ST_SCROLL,
         tmw_pkg::ST_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = tmw_pkg::MEM_ADDR_W'(sweep_ff);
            ram_req.wdata = {blank_ff, tmw_pkg::CH_SPACE};
            sweep_in      = sweep_ff + 1'b1;
         end
         tmw_pkg::ST_READ: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_cell_in = rd_data;
            end
         end
         tmw_pkg::ST_DONE: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_cell_in = '0;
            end
         end
         default: ;
      endcase

      // Result register
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = 5'(8'(crow_in));
         rsp_col_in   = 7'(8'(ccol_in));
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_cell_in  = rsp_cell_ff;
         rsp_row_in   = rsp_row_ff;
         rsp_col_in   = rsp_col_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmw_pkg::ST_INIT;
         crow_ff      <= '0;
         ccol_ff      <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         end_ff       <= CELL_LAST;
         blank_ff     <= tmw_pkg::BLANK_COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crow_ff      <= crow_in;
         ccol_ff      <= ccol_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) blank_ff <= csr_wdata;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_cell_ff <= rsp_cell_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_value     = rsp_cell_ff;
   assign rsp_cursor_row_now = rsp_row_ff;
   assign rsp_cursor_col_now = rsp_col_ff;

endmodule

// ===== src/text_mode_terminal_writer.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  op, char_code, char_color, target_row, target_col
// rsp_      out        rsp_tvalid/rsp_tready  cell_value, cursor_row_now, cursor_col_now
// csr_      in         csr_we                 blank_color
//
// Steps: put, backspace, set cursor and unused codes need no state beyond idle; read cell goes
// through the read state (registered read port of the cell store); a put that scrolls blanks
// the new bottom row one cell per cycle, and clear every cell likewise, before the done state.
// Scrolling moves a row pointer, so no cells are copied.
// Reset: a clearing pass over all SCREEN_WIDTH*SCREEN_HEIGHT cells zeroes the store; no
// transaction is taken meanwhile, csr writes are.
// Stalls: a held result blocks the next command only once the result register is full and
// rsp_tready is low.
module text_mode_terminal_writer #(
   parameter int SCREEN_WIDTH  = tmw_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tmw_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] op, [10:3] char_code, [18:11] char_color, [23:19] target_row,
   // [30:24] target_col, [31] zero
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] cell_value, [20:16] cursor_row_now, [27:21] cursor_col_now, [31:28] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   tmw_pkg::ram_req_type ram_req;
   logic [15:0]          rd_data;
   logic [15:0]          cell_value;
   logic [4:0]           cursor_row_now;
   logic [6:0]           cursor_col_now;

   // Command sequencer and cursor
   tmw_ctrl #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_tvalid),
      .req_ready          (req_tready),
      .req_op             (req_tdata[2:0]),
      .req_char_code      (req_tdata[10:3]),
      .req_char_color     (req_tdata[18:11]),
      .req_target_row     (req_tdata[23:19]),
      .req_target_col     (req_tdata[30:24]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_cell_value     (cell_value),
      .rsp_cursor_row_now (cursor_row_now),
      .rsp_cursor_col_now (cursor_col_now),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .ram_req            (ram_req),
      .rd_data            (rd_data)
   );

   // Screen cell store
   tmw_cell_ram #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_cell_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign rsp_tdata = {4'b0, cursor_col_now, cursor_row_now, cell_value};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int SCR_W           = tmw_pkg::SCREEN_WIDTH_DEF;
   localparam int SCR_H           = tmw_pkg::SCREEN_HEIGHT_DEF;
   localparam int CELLS           = SCR_W * SCR_H;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 2 * SCR_W + 20;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int PHASE_ITEMS     = 430;

   // One command as packed on req_tdata[30:0]
   typedef struct packed {
      logic [6:0] col;
      logic [4:0] row;
      logic [7:0] color;
      logic [7:0] ch;
      logic [2:0] op;
   } console_cmd_type;

   // One response as packed on rsp_tdata[27:0]
   typedef struct packed {
      logic [6:0]  col;
      logic [4:0]  row;
      logic [15:0] cell_value;
   } console_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   // Console model state
   logic [15:0] screen_model [0:CELLS-1];
   int          cur_row_m;
   int          cur_col_m;
   logic [7:0]  blank_color_m;

   console_result_type expected_results[$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   bit  no_idle = 1'b0;
   bit  hold_off_req = 1'b0;
   int  stall_left = 0;

   text_mode_terminal_writer #(
      .SCREEN_WIDTH  (SCR_W),
      .SCREEN_HEIGHT (SCR_H)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Console model
   // ---------------------------------------------------------------
   function automatic void reset_console_model();
      for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
      cur_row_m     = 0;
      cur_col_m     = 0;
      blank_color_m = tmw_pkg::BLANK_COLOR_RESET;
   endfunction

   // Newline; past the last row, rows shift up and the bottom row is blanked
   function automatic void advance_line();
      cur_col_m = 0;
      cur_row_m++;
      if (cur_row_m >= SCR_H) begin
         for (int i = 0; i < CELLS - SCR_W; i++) begin
            screen_model[i] = screen_model[i + SCR_W];
         end
         for (int i = CELLS - SCR_W; i < CELLS; i++) begin
            screen_model[i] = {blank_color_m, tmw_pkg::CH_SPACE};
         end
         cur_row_m = SCR_H - 1;
      end
   endfunction

   function automatic console_result_type predict_console(console_cmd_type c);
      console_result_type r;
      int trow;
      int tcol;
      trow = (c.row > SCR_H - 1) ? SCR_H - 1 : int'(c.row);
      tcol = (c.col > SCR_W - 1) ? SCR_W - 1 : int'(c.col);
      r.cell_value = '0;
      case (c.op)
         tmw_pkg::OP_PUT: begin
            if (c.ch == tmw_pkg::CH_NEWLINE) begin
               advance_line();
            end else if (c.ch == tmw_pkg::CH_RETURN) begin
               cur_col_m = 0;
            end else begin
               screen_model[cur_row_m * SCR_W + cur_col_m] = {c.color, c.ch};
               cur_col_m++;
               if (cur_col_m >= SCR_W) advance_line();
            end
         end
         tmw_pkg::OP_BKSP: begin
            if (cur_col_m > 0) begin
               cur_col_m--;
               screen_model[cur_row_m * SCR_W + cur_col_m] =
                  {blank_color_m, tmw_pkg::CH_SPACE};
            end
         end
         tmw_pkg::OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen_model[i] = {blank_color_m, tmw_pkg::CH_SPACE};
            end
            cur_row_m = 0;
            cur_col_m = 0;
         end
         tmw_pkg::OP_SETCUR: begin
            cur_row_m = trow;
            cur_col_m = tcol;
         end
         tmw_pkg::OP_READ: begin
            r.cell_value = screen_model[trow * SCR_W + tcol];
         end
         default: ;
      endcase
      r.row = cur_row_m[4:0];
      r.col = cur_col_m[6:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Prediction on accepted commands, checking on accepted responses
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got_v,
                                  input int unsigned want_v);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got_v, want_v, $time);
   endtask

   always @(posedge clock) begin
      console_result_type want;
      console_result_type got;
      if (reset) begin
         reset_console_model();
         expected_results.delete();
      end else begin
         if (csr_we) blank_color_m = csr_wdata;
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_console(console_cmd_type'(req_tdata[30:0])));
         if (rsp_tvalid && rsp_tready) begin
            got = console_result_type'(rsp_tdata[27:0]);
            if (expected_results.size() == 0) begin
               report_mismatch("response with none expected", rsp_tdata, 0);
            end else begin
               want = expected_results.pop_front();
               if (got.cell_value !== want.cell_value)
                  report_mismatch("cell_value", 32'(got.cell_value), 32'(want.cell_value));
               if (got.row !== want.row)
                  report_mismatch("cursor_row_now", 32'(got.row), 32'(want.row));
               if (got.col !== want.col)
                  report_mismatch("cursor_col_now", 32'(got.col), 32'(want.col));
            end
         end
      end
   end

   // Watchdog: cycles without any transaction on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Idle lengths: mostly short, a few long
   // ---------------------------------------------------------------
   function automatic int idle_len();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 50))
                                         : int'($urandom_range(1, 3));
   endfunction

   function automatic int sender_gap();
      if (no_idle) return 0;
      return ($urandom_range(0, 99) < 30) ? idle_len() : 0;
   endfunction

   // Response side: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 99) < 15) begin
            stall_left = idle_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic console_cmd_type mk_cmd(input logic [2:0] op, input logic [7:0] ch,
                                              input logic [7:0] color, input logic [4:0] row,
                                              input logic [6:0] col);
      console_cmd_type c;
      c.op    = op;
      c.ch    = ch;
      c.color = color;
      c.row   = row;
      c.col   = col;
      return c;
   endfunction

   // Offer one command and hold it until accepted
   task automatic send_cmd(input console_cmd_type c, input int gap);
      req_tdata  <= {1'b0, c};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every response is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_blank_color(input logic [7:0] v);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly text with line breaks; cursor moves biased toward the bottom to force scrolls
   function automatic console_cmd_type rand_console_cmd();
      console_cmd_type c;
      int kind;
      c    = console_cmd_type'(31'($urandom()));
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         c.op = tmw_pkg::OP_PUT;
         case ($urandom_range(0, 19))
            0, 1: c.ch = tmw_pkg::CH_NEWLINE;
            2:    c.ch = tmw_pkg::CH_RETURN;
            default: ;
         endcase
      end else if (kind < 63) begin
         c.op = tmw_pkg::OP_BKSP;
      end else if (kind < 64) begin
         c.op = tmw_pkg::OP_CLEAR;
      end else if (kind < 74) begin
         c.op = tmw_pkg::OP_SETCUR;
         if ($urandom_range(0, 1)) c.row = 5'($urandom_range(20, 31));
      end else if (kind < 96) begin
         c.op = tmw_pkg::OP_READ;
      end else begin
         c.op = 3'($urandom_range(5, 7));
      end
      return c;
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      send_cmd(mk_cmd(tmw_pkg::OP_PUT, 8'h41, 8'h00, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_PUT, 8'h00, 8'h5A, 5'd0, 7'd0), sender_gap());
      // backspace blanks the last character
      send_cmd(mk_cmd(tmw_pkg::OP_BKSP, 8'hFF, 8'hFF, 5'd31, 7'd127), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd0, 7'd1), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd0, 7'd2), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_PUT, tmw_pkg::CH_NEWLINE, 8'h33, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_PUT, 8'h78, 8'h21, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_PUT, tmw_pkg::CH_RETURN, 8'h44, 5'd0, 7'd0), sender_gap());
      // backspace at column zero does nothing
      send_cmd(mk_cmd(tmw_pkg::OP_BKSP, 8'h00, 8'h00, 5'd0, 7'd0), sender_gap());
      // out of range targets saturate
      send_cmd(mk_cmd(tmw_pkg::OP_SETCUR, 8'h00, 8'h00, 5'd31, 7'd127), sender_gap());
      // last cell: wrap and scroll
      send_cmd(mk_cmd(tmw_pkg::OP_PUT, 8'h5A, 8'hC3, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd23, 7'd79), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'hFF, 8'hFF, 5'd31, 7'd127), sender_gap());
      // newline on the last row scrolls
      send_cmd(mk_cmd(tmw_pkg::OP_PUT, tmw_pkg::CH_NEWLINE, 8'h00, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd22, 7'd79), sender_gap());
      // unused codes
      send_cmd(mk_cmd(3'd5, 8'h00, 8'h00, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(3'd6, 8'hA5, 8'h5A, 5'd21, 7'd85), sender_gap());
      send_cmd(mk_cmd(3'd7, 8'hFF, 8'hFF, 5'd31, 7'd127), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_SETCUR, 8'hFF, 8'hFF, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd0, 7'd0), sender_gap());
      send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd24, 7'd79), sender_gap());
      wait_idle();
   endtask

   // Blanking on clear, scroll and backspace at the color extremes
   task automatic test_blank_color();
      logic [7:0] colors [2];
      colors[0] = 8'h00;
      colors[1] = 8'hFF;
      foreach (colors[k]) begin
         write_blank_color(colors[k]);
         send_cmd(mk_cmd(tmw_pkg::OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0), sender_gap());
         send_cmd(mk_cmd(tmw_pkg::OP_SETCUR, 8'h00, 8'h00, 5'd24, 7'd5), sender_gap());
         send_cmd(mk_cmd(tmw_pkg::OP_BKSP, 8'h00, 8'h00, 5'd0, 7'd0), sender_gap());
         send_cmd(mk_cmd(tmw_pkg::OP_PUT, tmw_pkg::CH_NEWLINE, 8'h00, 5'd0, 7'd0),
                  sender_gap());
         send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd24, 7'd0), sender_gap());
         send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd23, 7'd4), sender_gap());
         send_cmd(mk_cmd(tmw_pkg::OP_READ, 8'h00, 8'h00, 5'd0, 7'd0), sender_gap());
         wait_idle();
      end
   endtask

   // Long response hold-off while commands keep coming back to back
   task automatic test_backpressure();
      hold_off_req = 1'b1;
      repeat (40) send_cmd(rand_console_cmd(), 0);
      wait_idle();
   endtask

   // Random phases, each under its own blank color
   task automatic test_random();
      logic [7:0] colors [4];
      colors[0] = 8'hFF;
      colors[1] = 8'($urandom_range(0, 255));
      colors[2] = 8'h00;
      colors[3] = 8'($urandom_range(0, 255));
      foreach (colors[k]) begin
         write_blank_color(colors[k]);
         no_idle = (k == 2);
         repeat (PHASE_ITEMS) send_cmd(rand_console_cmd(), sender_gap());
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_blank_color();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
